/* src/mfe_pkg.sv */
// Shared types and constants for the meter frame encoder.
// No dependencies; every other file of the block imports this package.
package mfe_pkg;

    localparam logic [7:0] FRAME_START = 8'h68;
    localparam logic [7:0] DATA_OFFSET = 8'h33;
    localparam logic [7:0] FRAME_STOP  = 8'h16;

    localparam int MFE_QUEUE_DEPTH = 4;

    // Byte positions of the back-end sequencer within one frame.
    localparam logic [3:0] STEP_START = 4'd0;
    localparam logic [3:0] STEP_ADDR0 = 4'd1;
    localparam logic [3:0] STEP_ADDR1 = 4'd2;
    localparam logic [3:0] STEP_ADDR2 = 4'd3;
    localparam logic [3:0] STEP_ADDR3 = 4'd4;
    localparam logic [3:0] STEP_ADDR4 = 4'd5;
    localparam logic [3:0] STEP_ADDR5 = 4'd6;
    localparam logic [3:0] STEP_START2 = 4'd7;
    localparam logic [3:0] STEP_CTRL  = 4'd8;
    localparam logic [3:0] STEP_LEN   = 4'd9;
    localparam logic [3:0] STEP_DATA  = 4'd10;
    localparam logic [3:0] STEP_SUM   = 4'd11;
    localparam logic [3:0] STEP_STOP  = 4'd12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] control_code;
        logic [7:0] data_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_out_item;

    // One classified data byte handed from the front end to the back end.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] control_code;
        logic [7:0] data_length;
        logic       first;
        logic       last;
    } t_cmd;

endpackage

/* src/mfe_front.sv */
// Front end: accepts data bytes and tags each as first and/or last of its frame.
// Depends on mfe_pkg.
module mfe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mfe_pkg::t_in_item i_item,
    input  logic            i_q_full,
    output logic            o_full,
    output logic            o_cmd_valid,
    output mfe_pkg::t_cmd   o_cmd
);
    import mfe_pkg::*;

    logic       r_in_frame, n_in_frame;
    logic [7:0] r_left, n_left;
    logic       w_accept;
    logic       w_last;

    assign o_full      = i_q_full;
    assign w_accept    = i_push && !i_q_full;
    assign o_cmd_valid = w_accept;

    always_comb begin
        n_in_frame = r_in_frame;
        n_left     = r_left;
        if (!r_in_frame) begin
            // A length of zero or one closes the frame on its first byte.
            w_last = (i_item.data_length <= 8'd1);
            if (w_accept && !w_last) begin
                n_in_frame = 1'b1;
                n_left     = i_item.data_length - 8'd1;
            end
        end else begin
            w_last = (r_left == 8'd1);
            if (w_accept) begin
                n_left     = r_left - 8'd1;
                n_in_frame = !w_last;
            end
        end
    end

    always_comb begin
        o_cmd.data_byte    = i_item.data_byte;
        o_cmd.control_code = i_item.control_code;
        o_cmd.data_length  = i_item.data_length;
        o_cmd.first        = !r_in_frame;
        o_cmd.last         = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_left     <= 8'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_left     <= n_left;
        end
    end

endmodule

/* src/mfe_queue.sv */
// Short command queue between the front end and the back end.
// Depends on mfe_pkg for the entry type.
module mfe_queue #(
    parameter int Depth = mfe_pkg::MFE_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mfe_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_nonempty,
    output mfe_pkg::t_cmd o_head
);
    import mfe_pkg::*;

    localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(Depth);
    localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);

    t_cmd          r_mem [Depth];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full     = (r_count == DEPTH_C);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + CW'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

endmodule

/* src/mfe_back.sv */
// Back end: steps through header, data, checksum and stop bytes per command,
// holding the meter address and the output register. Depends on mfe_pkg.
module mfe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [47:0]     i_cfg_data,
    input  logic            i_cmd_valid,
    input  mfe_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    output logic            empty,
    input  logic            pop,
    output mfe_pkg::t_out_item o_result
);
    import mfe_pkg::*;

    logic [47:0] r_address;
    logic        r_busy, n_busy;
    logic [3:0]  r_step, n_step;
    logic [3:0]  w_step;
    logic [7:0]  r_sum, n_sum;
    t_out_item   r_out, n_out;
    logic        r_out_valid;
    logic        w_adv;

    assign w_step    = r_busy ? r_step : (i_cmd.first ? STEP_START : STEP_DATA);
    assign w_adv     = i_cmd_valid && (!r_out_valid || pop);
    assign o_cmd_pop = w_adv && ((w_step == STEP_STOP) ||
                                 ((w_step == STEP_DATA) && !i_cmd.last));
    assign empty     = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        n_out.frame_end = 1'b0;
        case (w_step)
            STEP_START, STEP_START2: n_out.frame_byte = FRAME_START;
            STEP_ADDR0: n_out.frame_byte = r_address[7:0];
            STEP_ADDR1: n_out.frame_byte = r_address[15:8];
            STEP_ADDR2: n_out.frame_byte = r_address[23:16];
            STEP_ADDR3: n_out.frame_byte = r_address[31:24];
            STEP_ADDR4: n_out.frame_byte = r_address[39:32];
            STEP_ADDR5: n_out.frame_byte = r_address[47:40];
            STEP_CTRL:  n_out.frame_byte = i_cmd.control_code;
            STEP_LEN:   n_out.frame_byte = i_cmd.data_length;
            STEP_DATA:  n_out.frame_byte = i_cmd.data_byte + DATA_OFFSET;
            STEP_SUM:   n_out.frame_byte = r_sum;
            STEP_STOP: begin
                n_out.frame_byte = FRAME_STOP;
                n_out.frame_end  = 1'b1;
            end
            default:    n_out.frame_byte = FRAME_STOP;
        endcase
    end

    always_comb begin
        n_sum  = r_sum;
        n_step = r_step;
        n_busy = r_busy;
        if (w_adv) begin
            if (w_step == STEP_START) begin
                n_sum = n_out.frame_byte;
            end else if (w_step <= STEP_DATA) begin
                n_sum = r_sum + n_out.frame_byte;
            end
            n_busy = !o_cmd_pop;
            if (w_step == STEP_LEN) begin
                // A zero-length frame goes straight from length to checksum.
                n_step = (i_cmd.data_length == 8'd0) ? STEP_SUM : STEP_DATA;
            end else begin
                n_step = w_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
        r_sum  <= n_sum;
        r_step <= n_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address   <= 48'd0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_address <= i_cfg_data;
            end
            r_busy <= n_busy;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* src/meter_frame_encoder.sv */
// Meter command frame encoder: top level joining front end, queue and back end.
// Depends on mfe_pkg, mfe_front, mfe_queue and mfe_back.
//
// Usage: data bytes enter through a queue-style port (push / full). The first
// byte of a frame also carries the control code and the data length; both are
// ignored on later bytes. Encoded frame bytes leave through a second
// queue-style port (empty / pop) with frame_end set on the closing 0x16 byte.
// The 48-bit meter address is written through i_cfg_we / i_cfg_data, by the
// user only while the block is idle (the block does not enforce this), and is
// sent low byte first in each header. A pushed byte passes the command queue
// and the output register before its first result reaches the result ports.
// Throughput: one output byte per cycle while the receiver pops and the queue
// is not empty. A middle data byte yields one output byte, the first byte of
// a frame eleven (header plus data), the last byte three (data, checksum,
// stop), a one-byte frame thirteen and a zero-length frame twelve; the output
// sequencer sets this rate. The queue takes up to QueueDepth bytes while a
// header goes out, then full stays high until the back end reaches the data.
// Reset clears frame state, queue, valid flag and address, not the output byte.
// When the receiver stops popping, the byte holds, the queue fills, full rises.
module meter_frame_encoder #(
    parameter int QueueDepth = mfe_pkg::MFE_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [47:0]         i_cfg_data,
    input  logic                push,
    output logic                full,
    input  mfe_pkg::t_in_item   i_item,
    output logic                empty,
    input  logic                pop,
    output mfe_pkg::t_out_item  o_result
);
    import mfe_pkg::*;

    logic q_full;
    logic cmd_wr;
    t_cmd cmd_in;
    logic cmd_pop;
    logic cmd_valid;
    t_cmd cmd_head;

    mfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_cmd_valid (cmd_wr),
        .o_cmd       (cmd_in)
    );

    mfe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (cmd_wr),
        .i_wr_cmd   (cmd_in),
        .o_full     (q_full),
        .i_rd       (cmd_pop),
        .o_nonempty (cmd_valid),
        .o_head     (cmd_head)
    );

    mfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

/* sim/mfe_checker.sv */
// Scoreboard for the meter frame encoder: watches the data, result and address ports,
// predicts every frame byte and compares each popped beat with the oldest prediction.
// Depends on mfe_pkg for the item types and the frame constants.
module mfe_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [47:0]         i_cfg_data,
    input  logic                push,
    input  logic                full,
    input  mfe_pkg::t_in_item   i_item,
    input  logic                empty,
    input  logic                pop,
    input  mfe_pkg::t_out_item  i_result,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mfe_pkg::*;

    logic [47:0] address_copy;
    logic        frame_open;
    logic [7:0]  bytes_left;
    logic [7:0]  frame_sum;
    t_out_item   frame_bytes_due[$];

    // Every byte from the first start flag through the data enters the checksum.
    task automatic due_byte(input logic [7:0] b);
        t_out_item r;
        frame_sum = frame_sum + b;
        r.frame_byte = b;
        r.frame_end = 1'b0;
        frame_bytes_due.push_back(r);
    endtask

    task automatic due_trailer();
        t_out_item r;
        r.frame_byte = frame_sum;
        r.frame_end = 1'b0;
        frame_bytes_due.push_back(r);
        r.frame_byte = FRAME_STOP;
        r.frame_end = 1'b1;
        frame_bytes_due.push_back(r);
        frame_open = 1'b0;
        bytes_left = '0;
        frame_sum = '0;
    endtask

    task automatic encode_data_byte(input t_in_item it);
        if (!frame_open) begin
            frame_sum = '0;
            due_byte(FRAME_START);
            for (int i = 0; i < 6; i++) begin
                due_byte(address_copy[8*i +: 8]);
            end
            due_byte(FRAME_START);
            due_byte(it.control_code);
            due_byte(it.data_length);
            frame_open = (it.data_length != 8'd0);
            bytes_left = it.data_length;
        end
        // A zero-length frame drops its data byte and closes at once.
        if (frame_open) begin
            due_byte(it.data_byte + DATA_OFFSET);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
                due_trailer();
            end
        end else begin
            due_trailer();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            address_copy = '0;
            frame_open = 1'b0;
            bytes_left = '0;
            frame_sum = '0;
            frame_bytes_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                address_copy = i_cfg_data;
            end
            // Results are checked before this edge's input is predicted, so a beat
            // that comes out too early finds nothing waiting.
            if (pop && !empty) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: beat with none expected: frame_byte %02h frame_end %0b",
                             $time, i_result.frame_byte, i_result.frame_end);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (i_result.frame_byte !== want.frame_byte) begin
                        $display("%0t: frame_byte expected %02h, actual %02h",
                                 $time, want.frame_byte, i_result.frame_byte);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_result.frame_end !== want.frame_end) begin
                        $display("%0t: frame_end expected %0b, actual %0b",
                                 $time, want.frame_end, i_result.frame_end);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (push && !full) begin
                encode_data_byte(i_item);
            end
        end
        o_pending = frame_bytes_due.size();
    end

endmodule

/* sim/testbench.sv */
// Top of the meter frame encoder testbench: clock, reset, data and address stimulus,
// random stalls on both sides, a watchdog and the verdict.
// Depends on mfe_pkg, meter_frame_encoder and mfe_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mfe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_FRAME_LEN = 40;
    localparam int RANDOM_BYTES   = 110;
    localparam int CALM_TAIL      = 30;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [47:0] cfg_data;
    logic        push;
    logic        full;
    t_in_item    byte_in;
    logic        empty;
    logic        pop;
    t_out_item   frame_out;
    int          fail_count;
    int          pending;
    logic        idling;

    meter_frame_encoder u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (byte_in),
        .empty      (empty),
        .pop        (pop),
        .o_result   (frame_out)
    );

    mfe_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .push         (push),
        .full         (full),
        .i_item       (byte_in),
        .empty        (empty),
        .pop          (pop),
        .i_result     (frame_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_in_item pack_item(input logic [7:0] d, input logic [7:0] c,
                                           input logic [7:0] l);
        t_in_item it;
        it.data_byte = d;
        it.control_code = c;
        it.data_length = l;
        return it;
    endfunction

    function automatic logic [47:0] pick_address();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return r[47:0];
            end
        endcase
    endfunction

    // Entered and left at a falling edge; push stays high after the beat so that
    // back-to-back items need no second assignment in one step.
    task automatic send_byte(input t_in_item it);
        if (idling && $urandom_range(0, 4) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        push = 1'b1;
        byte_in = it;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    // The address moves only once every predicted byte has been popped.
    task automatic load_address(input logic [47:0] a);
        push = 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_data = a;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Result side: pop is high except during random stall bursts.
    initial begin
        int stall;
        stall = 0;
        pop = 1'b0;
        forever begin
            @(negedge clk);
            if (stall == 0 && idling && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 17);
            end
            if (stall > 0) begin
                pop = 1'b0;
                stall--;
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("meter_frame_encoder verification failed");
        $finish;
    end

    initial begin
        int       remaining;
        int       sent;
        t_in_item it;
        logic [7:0] len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        byte_in = '0;
        idling = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: reset address, zero length, offset wrap, ignored fields
        // on later bytes, extreme addresses and an address change inside a frame.
        send_byte(pack_item(8'h00, 8'h00, 8'd1));
        load_address(48'h6655_4433_2211);
        send_byte(pack_item(8'hAB, 8'hFF, 8'd0));
        send_byte(pack_item(8'hFF, 8'h11, 8'd3));
        send_byte(pack_item(8'hCD, 8'hFF, 8'd0));
        send_byte(pack_item(8'hCC, 8'h00, 8'hFF));
        load_address(48'hFFFF_FFFF_FFFF);
        send_byte(pack_item(8'h7F, 8'hA5, 8'd2));
        load_address(48'h8000_0000_0001);
        send_byte(pack_item(8'h80, 8'h5A, 8'd7));
        send_byte(pack_item(8'h01, 8'h5A, 8'd1));
        load_address(48'h0);
        send_byte(pack_item(8'h33, 8'h91, 8'd1));
        send_byte(pack_item(8'h55, 8'h80, 8'd0));

        // Random frames, mostly short, a long one first; address writes land both
        // between frames and inside open ones.
        remaining = 0;
        for (sent = 0; sent < RANDOM_BYTES; sent++) begin
            if (remaining == 0) begin
                if (sent > 0 && $urandom_range(0, 5) == 0) begin
                    load_address(pick_address());
                end
                if (sent == 0) begin
                    len = 8'(LONG_FRAME_LEN);
                end else begin
                    case ($urandom_range(0, 19))
                        0: len = 8'd0;
                        1: len = 8'($urandom_range(9, 40));
                        default: len = 8'($urandom_range(1, 8));
                    endcase
                end
                idling = (sent < RANDOM_BYTES - CALM_TAIL) && ($urandom_range(0, 3) != 0);
                it.data_length = len;
                remaining = int'(len);
            end else begin
                if ($urandom_range(0, 15) == 0) begin
                    load_address(pick_address());
                end
                it.data_length = 8'($urandom_range(0, 255));
            end
            it.data_byte = 8'($urandom_range(0, 255));
            it.control_code = 8'($urandom_range(0, 255));
            send_byte(it);
            if (remaining > 0) begin
                remaining--;
            end
        end

        push = 1'b0;
        idling = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("meter_frame_encoder verification clean");
        end else begin
            $display("meter_frame_encoder verification failed");
        end
        $finish;
    end

endmodule
